### src/spbs_pkg.sv
// Shared types and constants for the scatter page row burst splitter.
// No dependencies; imported by every module of the block.
package spbs_pkg;

	// Field and state widths
	localparam int ADDR_W     = 48;  // byte address
	localparam int PBYTES_W   = 13;  // page size in bytes
	localparam int WOFF_W     = 45;  // burst start as word address
	localparam int WORDS_W    = 10;  // burst length in words
	localparam int ROWB_W     = 17;  // row width in bytes
	localparam int STRIDE_W   = 21;  // row stride in bytes
	localparam int ROWS_W     = 16;  // row counter
	localparam int PR_W       = 23;  // signed page remainder / pending gap
	localparam int BURSTS_W   = 5;   // bursts emitted for one page

	// At most this many bursts per page; the rest of the page is dropped
	localparam logic [BURSTS_W-1:0] MAX_BURSTS = 5'd31;

	// Entries in the page queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Configuration register indexes (byte address is index * 4)
	typedef enum logic [1:0] {
		REG_ROW_BYTES  = 2'd0,
		REG_ROW_STRIDE = 2'd1,
		REG_ROW_COUNT  = 2'd2
	} reg_idx_t;

	// One page of the scatter list
	typedef struct packed {
		logic [ADDR_W-1:0]   page_offset;
		logic [PBYTES_W-1:0] page_bytes;
	} page_t;

	// Settings seen by the burst engine
	typedef struct packed {
		logic [ROWB_W-1:0]   row_bytes;
		logic [STRIDE_W-1:0] gap;        // stride minus width, saturated at zero
		logic [ROWS_W-1:0]   row_count;  // zero already mapped to one
	} cfg_t;

	// One result beat, without the last flag
	typedef struct packed {
		logic [WOFF_W-1:0]  word_offset;
		logic [WORDS_W-1:0] words;
		logic               frame_end;
	} burst_t;

endpackage

### src/spbs_cfg_regs.sv
// APB register file: row width, row stride and row count.
// Derives the row gap and effective row count for the engine; uses spbs_pkg.
module spbs_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output spbs_pkg::cfg_t     cfg
);
	import spbs_pkg::*;

	localparam logic [ROWB_W-1:0]   RST_ROW_BYTES  = 17'd4096;
	localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE = 21'd4096;
	localparam logic [ROWS_W-1:0]   RST_ROW_COUNT  = 16'd1080;

	logic [ROWB_W-1:0]   row_bytes_q;
	logic [STRIDE_W-1:0] row_stride_q;
	logic [ROWS_W-1:0]   row_count_q;
	logic [STRIDE_W-1:0] gap_q;
	logic [ROWS_W-1:0]   rows_eff_q;
	logic                wr_en;
	logic [1:0]          reg_idx;
	logic [STRIDE_W-1:0] width_ext;

	assign wr_en     = psel & penable & pwrite;
	assign reg_idx   = paddr[3:2];
	assign width_ext = STRIDE_W'(row_bytes_q);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= RST_ROW_BYTES;
			row_stride_q <= RST_ROW_STRIDE;
			row_count_q  <= RST_ROW_COUNT;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROW_BYTES:  row_bytes_q  <= pwdata[ROWB_W-1:0];
				REG_ROW_STRIDE: row_stride_q <= pwdata[STRIDE_W-1:0];
				REG_ROW_COUNT:  row_count_q  <= pwdata[ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// derived values, registered to keep the subtract off the engine path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= '0;
			rows_eff_q <= RST_ROW_COUNT;
		end else begin
			gap_q      <= (row_stride_q > width_ext) ? row_stride_q - width_ext : '0;
			rows_eff_q <= (row_count_q == '0) ? ROWS_W'(1) : row_count_q;
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_ROW_BYTES:  prdata = 32'(row_bytes_q);
			REG_ROW_STRIDE: prdata = 32'(row_stride_q);
			REG_ROW_COUNT:  prdata = 32'(row_count_q);
			default:        prdata = '0;
		endcase
	end

	assign cfg.row_bytes = row_bytes_q;
	assign cfg.gap       = gap_q;
	assign cfg.row_count = rows_eff_q;

endmodule

### src/spbs_page_queue.sv
// Front of the block: takes page beats and queues them for the burst engine.
// Small register FIFO of spbs_pkg::page_t entries; uses spbs_pkg.
module spbs_page_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  spbs_pkg::page_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output spbs_pkg::page_t pop_data
);
	import spbs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	page_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid & push_ready;
	assign do_pop     = pop_valid & pop_ready;
	assign pop_data   = slot_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### src/spbs_burst_engine.sv
// Back of the block: walks one page a step per cycle unless output stalls, skips row
// gaps, emits bursts and the frame end marker into a registered beat. Uses spbs_pkg.
module spbs_burst_engine #(
	parameter int PAGE_CAP_BYTES = 4096,
	parameter int WORD_SHIFT     = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  spbs_pkg::cfg_t   cfg,
	input  logic             page_valid,
	output logic             page_pop,
	input  spbs_pkg::page_t  page,
	output logic             out_valid,
	input  logic             out_ready,
	output spbs_pkg::burst_t out_burst,
	output logic             out_last
);
	import spbs_pkg::*;

	localparam logic [ROWB_W-1:0] CAP = ROWB_W'(PAGE_CAP_BYTES);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t              state_q;
	logic signed [PR_W-1:0] pr_q;       // bytes left in page, negative = gap to skip
	logic [ADDR_W-1:0]   wa_q;
	logic [ROWB_W-1:0]   rbl_q;
	logic                row_open_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [BURSTS_W-1:0] bursts_q;
	burst_t              hold_q;        // newest result, waits to learn if it is last
	logic                hold_v_q;
	burst_t              out_burst_q;
	logic                out_last_q;
	logic                out_v_q;

	logic                   can_push;
	logic                   step_ok;
	logic                   out_load;
	logic signed [PR_W-1:0] neg_pr;
	logic [PR_W-2:0]        deficit;
	logic signed [PR_W-1:0] ld_pr;
	logic [ADDR_W-1:0]      ld_wa;
	logic                   ld_pos;
	logic [ROWB_W-1:0]      rbl_eff;
	logic [ROWB_W-1:0]      pr_bytes;
	logic [ROWB_W-1:0]      b_min;
	logic [ROWB_W-1:0]      b;
	logic [ROWB_W-1:0]      b_sh;
	logic [ROWB_W-1:0]      rbl_left;
	logic signed [PR_W-1:0] pr_burst;
	logic signed [PR_W-1:0] pr_gap;
	logic [ROWS_W:0]        rows_inc;
	logic [ADDR_W-1:0]      wa_sh;

	logic                   step_emit;
	burst_t                 step_res;
	logic                   step_stay;
	logic signed [PR_W-1:0] pr_nx;
	logic [ADDR_W-1:0]      wa_nx;
	logic [ROWB_W-1:0]      rbl_nx;
	logic                   open_nx;
	logic [ROWS_W-1:0]      rows_nx;
	logic [BURSTS_W-1:0]    bursts_nx;

	assign can_push = !out_v_q || out_ready;
	assign step_ok  = !hold_v_q || can_push;
	assign page_pop = (state_q == ST_IDLE) && page_valid && step_ok;
	// held result moves to the output register this cycle
	assign out_load = hold_v_q && can_push && ((state_q == ST_IDLE) || step_emit);

	// page load: start address skips any gap left from the previous page
	assign neg_pr  = -pr_q;
	assign deficit = neg_pr[PR_W-2:0];
	assign ld_pr   = pr_q + $signed(PR_W'(page.page_bytes));
	assign ld_wa   = page.page_offset + ADDR_W'(deficit);
	assign ld_pos  = !ld_pr[PR_W-1] && (ld_pr != '0);

	// burst size: least of page rest, page cap and row rest
	assign rbl_eff  = row_open_q ? rbl_q : cfg.row_bytes;
	assign pr_bytes = pr_q[ROWB_W-1:0];
	assign b_min    = (CAP < pr_bytes) ? CAP : pr_bytes;
	assign b        = (rbl_eff < b_min) ? rbl_eff : b_min;
	assign b_sh     = b >> WORD_SHIFT;
	assign wa_sh    = wa_q >> WORD_SHIFT;
	assign rbl_left = rbl_eff - b;
	assign pr_burst = pr_q - $signed(PR_W'(b));
	assign pr_gap   = pr_q - $signed(PR_W'(cfg.gap));
	assign rows_inc = {1'b0, rows_q} + 1'b1;

	// one step: a burst, the end of a row, or dropping the page rest once the budget is spent
	always_comb begin
		step_emit = 1'b0;
		step_res  = '0;
		step_stay = 1'b1;
		pr_nx     = pr_q;
		wa_nx     = wa_q;
		rbl_nx    = rbl_q;
		open_nx   = row_open_q;
		rows_nx   = rows_q;
		bursts_nx = bursts_q;
		if (rbl_eff != '0) begin
			open_nx = 1'b1;
			if (bursts_q == MAX_BURSTS) begin
				// burst budget spent: drop the rest of the page
				pr_nx     = '0;
				rbl_nx    = rbl_eff;
				step_stay = 1'b0;
			end else begin
				step_emit            = 1'b1;
				step_res.word_offset = wa_sh[WOFF_W-1:0];
				step_res.words       = b_sh[WORDS_W-1:0];
				step_res.frame_end   = 1'b0;
				bursts_nx            = bursts_q + 1'b1;
				rbl_nx               = rbl_left;
				pr_nx                = pr_burst;
				wa_nx                = wa_q + ADDR_W'(b);
				step_stay            = (rbl_left == '0) ||
					(!pr_burst[PR_W-1] && (pr_burst != '0));
			end
		end else begin
			open_nx = 1'b0;
			if (rows_inc >= {1'b0, cfg.row_count}) begin
				// frame done: marker, then a fresh frame with the next page
				step_emit = 1'b1;
				step_res.frame_end = 1'b1;
				rows_nx   = '0;
				pr_nx     = '0;
				wa_nx     = '0;
				step_stay = 1'b0;
			end else begin
				rows_nx   = rows_inc[ROWS_W-1:0];
				pr_nx     = pr_gap;
				wa_nx     = wa_q + ADDR_W'(cfg.gap);
				step_stay = !pr_gap[PR_W-1] && (pr_gap != '0);
			end
		end
	end

	// sequencer, held result and output beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pr_q        <= '0;
			wa_q        <= '0;
			rbl_q       <= '0;
			row_open_q  <= 1'b0;
			rows_q      <= '0;
			bursts_q    <= '0;
			hold_q      <= '0;
			hold_v_q    <= 1'b0;
			out_burst_q <= '0;
			out_last_q  <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (out_v_q && out_ready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					// flush the page's final result with last set
					if (hold_v_q && can_push) begin
						out_burst_q <= hold_q;
						out_last_q  <= 1'b1;
						out_v_q     <= 1'b1;
						hold_v_q    <= 1'b0;
					end
					if (page_pop) begin
						pr_q     <= ld_pr;
						wa_q     <= ld_wa;
						bursts_q <= '0;
						if (ld_pos) begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (step_ok) begin
						pr_q       <= pr_nx;
						wa_q       <= wa_nx;
						rbl_q      <= rbl_nx;
						row_open_q <= open_nx;
						rows_q     <= rows_nx;
						bursts_q   <= bursts_nx;
						if (step_emit) begin
							if (hold_v_q) begin
								out_burst_q <= hold_q;
								out_last_q  <= 1'b0;
								out_v_q     <= 1'b1;
							end
							hold_q   <= step_res;
							hold_v_q <= 1'b1;
						end
						if (!step_stay) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_v_q;
	assign out_burst = out_burst_q;
	assign out_last  = out_last_q;

endmodule

### src/scatter_page_row_burst_splitter.sv
// Scatter page row burst splitter: page queue, burst engine and APB registers.
// Path: a page beat is queued, then loaded by the burst engine, which walks it one
// step per burst and per row end, stalling on output back-pressure; each burst waits
// in a hold register to learn if it is last, then goes to the output register.
// Reset: registers to 4096 / 4096 / 1080, queue empty, no row open, frame restarts.
module scatter_page_row_burst_splitter #(
	parameter int PAGE_CAP_BYTES = 4096,
	parameter int WORD_SHIFT     = 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// page beats
	input  logic                          page_valid,
	output logic                          page_ready,
	input  logic [spbs_pkg::ADDR_W-1:0]   page_offset,
	input  logic [spbs_pkg::PBYTES_W-1:0] page_bytes,
	// burst beats
	output logic                          burst_valid,
	input  logic                          burst_ready,
	output logic [spbs_pkg::WOFF_W-1:0]   burst_word_offset,
	output logic [spbs_pkg::WORDS_W-1:0]  burst_words,
	output logic                          frame_end,
	output logic                          last
);
	import spbs_pkg::*;

	cfg_t   cfg;
	page_t  in_page;
	page_t  q_page;
	logic   q_valid;
	logic   q_pop;
	burst_t res;

	assign pready = 1'b1;

	assign in_page.page_offset = page_offset;
	assign in_page.page_bytes  = page_bytes;

	spbs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	spbs_page_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (page_valid),
		.push_ready (page_ready),
		.push_data  (in_page),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (q_page)
	);

	spbs_burst_engine #(
		.PAGE_CAP_BYTES (PAGE_CAP_BYTES),
		.WORD_SHIFT     (WORD_SHIFT)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.page_valid (q_valid),
		.page_pop   (q_pop),
		.page       (q_page),
		.out_valid  (burst_valid),
		.out_ready  (burst_ready),
		.out_burst  (res),
		.out_last   (last)
	);

	assign burst_word_offset = res.word_offset;
	assign burst_words       = res.words;
	assign frame_end         = res.frame_end;

endmodule

### dv/scatter_page_row_burst_splitter_test.sv
`timescale 1ns / 100ps
// Self-checking bench for scatter_page_row_burst_splitter: random page beats and stalls,
// an APB driver, and a scoreboard that predicts every burst. Depends on src/spbs_pkg.sv.
module scatter_page_row_burst_splitter_test;

	localparam int PAGE_CAP_BYTES = 4096;
	localparam int WORD_SHIFT     = 3;
	localparam int RESET_CYCLES   = 7;
	localparam int SETTLE_CYCLES  = 200;  // covers pages still in flight that yield nothing
	localparam int HOLD_CYCLES    = 400;  // long receiver hold-off
	localparam int QUIET_LIMIT    = 4000; // cycles without any beat before giving up
	localparam int MAX_REPORTS    = 10;

	// One burst beat as seen on the output
	typedef struct packed {
		logic [spbs_pkg::WOFF_W-1:0]  word_offset;
		logic [spbs_pkg::WORDS_W-1:0] words;
		logic                         frame_end;
		logic                         is_last;
	} burst_beat_t;

	// Burst planner: mirrors the splitter state and holds the bursts still due
	class burst_plan_checker;
		logic [spbs_pkg::ROWB_W-1:0]   row_bytes;
		logic [spbs_pkg::STRIDE_W-1:0] row_stride;
		logic [spbs_pkg::ROWS_W-1:0]   row_count;
		logic [spbs_pkg::ADDR_W-1:0]   write_addr;
		longint                        page_left;  // negative: gap bytes still to skip
		logic [spbs_pkg::ROWB_W-1:0]   row_left;
		logic [spbs_pkg::ROWS_W-1:0]   rows_done;
		bit                            row_open;
		burst_beat_t                   due[$];
		int                            mismatches;

		function new();
			row_bytes  = 17'd4096;
			row_stride = 21'd4096;
			row_count  = 16'd1080;
			write_addr = '0;
			page_left  = 0;
			row_left   = 17'd4096;
			rows_done  = '0;
			row_open   = 1'b0;
			mismatches = 0;
		endfunction

		function void set_register(spbs_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				spbs_pkg::REG_ROW_BYTES:  row_bytes  = value[spbs_pkg::ROWB_W-1:0];
				spbs_pkg::REG_ROW_STRIDE: row_stride = value[spbs_pkg::STRIDE_W-1:0];
				spbs_pkg::REG_ROW_COUNT:  row_count  = value[spbs_pkg::ROWS_W-1:0];
				default: ;
			endcase
		endfunction

		// Split one accepted page into bursts and queue them
		function void plan_page(logic [spbs_pkg::ADDR_W-1:0] offset,
				logic [spbs_pkg::PBYTES_W-1:0] size);
			longint      chunk;
			longint      gap;
			int          bursts;
			burst_beat_t beat;
			burst_beat_t page_beats[$];
			logic [spbs_pkg::ROWS_W-1:0] rows_per_frame;

			write_addr = offset + (page_left < 0 ? 48'(-page_left) : 48'd0);
			page_left += longint'(size);
			bursts = 0;
			while (page_left > 0) begin
				if (!row_open) begin
					row_left = row_bytes;
					row_open = 1'b1;
				end
				if (row_left > 0) begin
					chunk = page_left;
					if (chunk > PAGE_CAP_BYTES) chunk = PAGE_CAP_BYTES;
					if (chunk > longint'(row_left)) chunk = longint'(row_left);
					// too many bursts: drop the rest of the page
					if (bursts == int'(spbs_pkg::MAX_BURSTS)) begin
						page_left = 0;
						break;
					end
					beat.word_offset = spbs_pkg::WOFF_W'(write_addr >> WORD_SHIFT);
					beat.words       = spbs_pkg::WORDS_W'(chunk >> WORD_SHIFT);
					beat.frame_end   = 1'b0;
					beat.is_last     = 1'b0;
					page_beats.push_back(beat);
					bursts++;
					row_left   = row_left - spbs_pkg::ROWB_W'(chunk);
					page_left -= chunk;
					write_addr = write_addr + 48'(chunk);
				end
				// row end: skip the gap, maybe close the frame
				if (row_left == 0) begin
					gap = row_stride > row_bytes ?
						longint'(row_stride) - longint'(row_bytes) : 0;
					page_left -= gap;
					write_addr = write_addr + 48'(gap);
					rows_done  = rows_done + 1'b1;
					row_open   = 1'b0;
					rows_per_frame = (row_count == 0) ? 16'd1 : row_count;
					if (rows_done >= rows_per_frame) begin
						beat = '0;
						beat.frame_end = 1'b1;
						page_beats.push_back(beat);
						rows_done  = '0;
						page_left  = 0;
						write_addr = '0;
						break;
					end
				end
			end
			foreach (page_beats[i]) begin
				beat = page_beats[i];
				beat.is_last = (i == page_beats.size() - 1);
				due.push_back(beat);
			end
		endfunction

		function void check_burst(burst_beat_t seen);
			burst_beat_t want;
			if (due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected burst off=%h words=%0d end=%b last=%b",
						$time, seen.word_offset, seen.words, seen.frame_end, seen.is_last);
				return;
			end
			want = due.pop_front();
			if (seen != want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$write("%0t: burst mismatch: expected off=%h words=%0d end=%b last=%b,",
						$time, want.word_offset, want.words, want.frame_end, want.is_last);
					$display(" got off=%h words=%0d end=%b last=%b",
						seen.word_offset, seen.words, seen.frame_end, seen.is_last);
				end
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [3:0]                    paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;
	logic                          page_valid = 1'b0;
	logic                          page_ready;
	logic [spbs_pkg::ADDR_W-1:0]   page_offset = '0;
	logic [spbs_pkg::PBYTES_W-1:0] page_bytes = '0;
	logic                          burst_valid;
	logic                          burst_ready = 1'b0;
	logic [spbs_pkg::WOFF_W-1:0]   burst_word_offset;
	logic [spbs_pkg::WORDS_W-1:0]  burst_words;
	logic                          frame_end;
	logic                          last;

	burst_plan_checker planner;
	bit hold_req = 1'b0;       // asks the receiver for a long hold-off
	bit steady_sender = 1'b0;  // sender offers pages back to back
	int quiet_cycles = 0;

	scatter_page_row_burst_splitter #(
		.PAGE_CAP_BYTES(PAGE_CAP_BYTES),
		.WORD_SHIFT    (WORD_SHIFT)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.page_valid       (page_valid),
		.page_ready       (page_ready),
		.page_offset      (page_offset),
		.page_bytes       (page_bytes),
		.burst_valid      (burst_valid),
		.burst_ready      (burst_ready),
		.burst_word_offset(burst_word_offset),
		.burst_words      (burst_words),
		.frame_end        (frame_end),
		.last             (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle lengths: mostly short, now and then long
	function automatic int sender_gap();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic int stall_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 70) return $urandom_range(1, 2);
		if (pick < 95) return $urandom_range(3, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [spbs_pkg::ADDR_W-1:0] rand_offset();
		return spbs_pkg::ADDR_W'({$urandom, $urandom}) & ~48'h7;
	endfunction

	// Offer one page beat and wait for it to be taken
	task automatic send_page(logic [spbs_pkg::ADDR_W-1:0] offset,
			logic [spbs_pkg::PBYTES_W-1:0] size);
		int gap;
		gap = steady_sender ? 0 : sender_gap();
		if (gap > 0) begin
			page_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		page_valid  <= 1'b1;
		page_offset <= offset;
		page_bytes  <= size;
		do @(posedge clk); while (!page_ready);
		planner.plan_page(offset, size);
	endtask

	// Setup and access phases, then the bus goes idle
	task automatic write_register(spbs_pkg::reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		planner.set_register(idx, value);
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		page_valid <= 1'b0;
		@(posedge clk);
		while (planner.due.size() != 0) @(posedge clk);
	endtask

	task automatic drain_and_settle();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(logic [16:0] width, logic [20:0] stride, logic [15:0] rows);
		drain_and_settle();
		write_register(spbs_pkg::REG_ROW_BYTES, 32'(width));
		write_register(spbs_pkg::REG_ROW_STRIDE, 32'(stride));
		write_register(spbs_pkg::REG_ROW_COUNT, 32'(rows));
	endtask

	// Random settings, then a run of pages: mostly whole aligned pages, some noise
	task automatic random_segment(int n_pages, bit with_hold, bit with_pause);
		logic [16:0] width;
		logic [20:0] stride;
		logic [15:0] rows;
		logic [spbs_pkg::ADDR_W-1:0]   offset;
		logic [spbs_pkg::PBYTES_W-1:0] size;
		int pick;

		pick = $urandom_range(0, 9);
		if (pick < 2) width = 17'(8 * $urandom_range(1, 16));
		else if (pick < 8) width = 17'(8 * $urandom_range(32, 512));
		else width = 17'(8 * $urandom_range(513, 8192));
		// stride below width now and then, gap saturates
		if ($urandom_range(0, 9) < 2) stride = 21'(width - 8 * $urandom_range(0, width / 8));
		else stride = 21'(width + 8 * $urandom_range(0, 512));
		pick = $urandom_range(0, 9);
		if (pick < 1) rows = 16'd0;
		else if (pick < 7) rows = 16'($urandom_range(1, 6));
		else rows = 16'($urandom_range(7, 40));
		apply_settings(width, stride, rows);

		steady_sender = with_hold || ($urandom_range(0, 3) == 0);
		if (with_hold) hold_req = 1'b1;
		for (int i = 0; i < n_pages; i++) begin
			if (with_pause && i == n_pages / 2) wait_for_results();
			pick = $urandom_range(0, 99);
			offset = rand_offset();
			if (pick < 10) offset[2:0] = 3'($urandom);
			pick = $urandom_range(0, 99);
			if (pick < 60) size = 13'd4096;
			else if (pick < 85) size = 13'(8 * $urandom_range(1, 512));
			else size = 13'($urandom_range(0, 4096));
			send_page(offset, size);
		end
		steady_sender = 1'b0;
	endtask

	// Receiver: random ready/stall phases plus the requested hold-off
	initial begin
		int phase_left;
		int hold_left;
		phase_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				phase_left = 0;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				burst_ready <= 1'b0;
			end else if (phase_left > 0) begin
				phase_left--;
			end else if (burst_ready) begin
				burst_ready <= 1'b0;
				phase_left = stall_len();
			end else begin
				burst_ready <= 1'b1;
				phase_left = ($urandom_range(0, 9) == 0) ?
					$urandom_range(100, 300) : $urandom_range(1, 30);
			end
		end
	end

	// Check every accepted burst beat
	always @(posedge clk) begin
		if (arst_n && burst_valid && burst_ready)
			planner.check_burst({burst_word_offset, burst_words, frame_end, last});
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (page_valid && page_ready) || (burst_valid && burst_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		planner = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: field extremes, empty page, odd sizes
		send_page(48'h0, 13'd4096);
		send_page('1, 13'd4096);
		send_page(48'h5555_5555_5550, 13'd0);
		send_page(48'hAAAA_AAAA_AAA8, 13'd1);
		send_page(rand_offset(), 13'd4095);

		// gap as big as a page: one page falls entirely inside it
		apply_settings(17'd256, 21'd8192, 16'd2);
		repeat (4) send_page(rand_offset(), 13'd4096);

		// large stride, one row per frame
		apply_settings(17'd256, 21'd1048576, 16'd1);
		repeat (3) send_page(rand_offset(), 13'd4096);

		// tiny rows: burst count cap per page; stride below width; most rows per frame
		apply_settings(17'd64, 21'd32, 16'd65535);
		repeat (2) send_page(rand_offset(), 13'd4096);

		// zero width rows only skip the gap
		apply_settings(17'd0, 21'd512, 16'd5);
		send_page(rand_offset(), 13'd4096);
		send_page(rand_offset(), 13'd4096);
		send_page(rand_offset(), 13'd1000);

		// wide rows, stride below width, zero row count
		apply_settings(17'd65536, 21'd256, 16'd0);
		repeat (3) send_page(rand_offset(), 13'd4096);

		// random part: first with a long receiver hold-off, then one with a sender pause
		random_segment(22, 1'b1, 1'b0);
		random_segment(22, 1'b0, 1'b1);
		repeat (3) random_segment(22, 1'b0, 1'b0);

		drain_and_settle();
		if (planner.mismatches == 0 && planner.due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
src/spbs_pkg.sv
src/spbs_cfg_regs.sv
src/spbs_page_queue.sv
src/spbs_burst_engine.sv
src/scatter_page_row_burst_splitter.sv
dv/scatter_page_row_burst_splitter_test.sv
